// ===== design/b64u_pkg.sv =====
// Shared types and helpers of the base64url codec.
// Holds the front-to-back job record and the alphabet mapping functions.
// No dependencies.
package b64u_pkg;

  localparam logic MODE_ENCODE = 1'b0;
  localparam logic MODE_DECODE = 1'b1;

  localparam logic [6:0] SEXTET_BAD = 7'h40;

  // One unit of work for the back end: a 24-bit group and how many results it gives
  typedef struct packed {
    logic        mode;
    logic [23:0] bits;
    logic [1:0]  last_idx;  // index of the final result of this job
    logic        last;      // the job ends the message
    logic        error;     // sticky error flag at the time of the job
  } job_t;

  // Map a sextet to its alphabet character
  function automatic logic [7:0] sextet_char(input logic [5:0] v);
    logic [7:0] c;
    if (v < 6'd26) begin
      c = 8'h41 + {2'b00, v};
    end else if (v < 6'd52) begin
      c = 8'h61 + {2'b00, v} - 8'd26;
    end else if (v < 6'd62) begin
      c = 8'h30 + {2'b00, v} - 8'd52;
    end else if (v == 6'd62) begin
      c = 8'h2D;
    end else begin
      c = 8'h5F;
    end
    return c;
  endfunction

  // Map a character to its sextet, SEXTET_BAD outside the alphabet
  function automatic logic [6:0] char_sextet(input logic [7:0] c);
    logic [6:0] s;
    if (c >= 8'h41 && c <= 8'h5A) begin
      s = 7'(c - 8'h41);
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      s = 7'(c - 8'h61 + 8'd26);
    end else if (c >= 8'h30 && c <= 8'h39) begin
      s = 7'(c - 8'h30 + 8'd52);
    end else if (c == 8'h2D) begin
      s = 7'd62;
    end else if (c == 8'h5F) begin
      s = 7'd63;
    end else begin
      s = SEXTET_BAD;
    end
    return s;
  endfunction

endpackage

// ===== design/b64u_front.sv =====
// Front end of the base64url codec: accepts items and gathers groups.
// Holds the mode register and group state; emits jobs. Depends on b64u_pkg.
module b64u_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic             cfg_wdata,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [7:0]       data_in,
  input  logic             last_in,
  output logic             job_valid,
  input  logic             job_ready,
  output b64u_pkg::job_t   job
);
  import b64u_pkg::*;

  logic        mode;
  logic [23:0] group_bits;
  logic [1:0]  group_count;
  logic        bad_input;

  logic [23:0] group_bits_next;
  logic [1:0]  group_count_next;
  logic        bad_input_next;
  logic        produce;
  logic        accept;
  logic [2:0]  n;
  logic [6:0]  sext;
  logic [23:0] enc_bits;
  logic [23:0] dec_bits;

  assign in_ready = job_ready;
  assign accept   = in_valid && in_ready;
  assign n        = {1'b0, group_count} + 3'd1;
  assign sext     = char_sextet(data_in);
  assign enc_bits = {group_bits[15:0], data_in};
  assign dec_bits = {group_bits[17:0], (sext == SEXTET_BAD) ? 6'd0 : sext[5:0]};

  // Classify the item: does it close a group, and what job does it form
  always_comb begin
    produce          = 1'b0;
    job.mode         = mode;
    job.bits         = 24'd0;
    job.last_idx     = 2'd0;
    job.last         = last_in;
    job.error        = bad_input;
    group_bits_next  = group_bits;
    group_count_next = group_count;
    bad_input_next   = bad_input;
    if (mode == MODE_ENCODE) begin
      if (n == 3'd3) begin
        produce          = 1'b1;
        job.bits         = enc_bits;
        job.last_idx     = 2'd3;
        group_bits_next  = 24'd0;
        group_count_next = 2'd0;
      end else begin
        produce          = last_in;
        job.bits         = (n == 3'd1) ? {enc_bits[7:0], 16'd0} : {enc_bits[15:0], 8'd0};
        job.last_idx     = (n == 3'd1) ? 2'd1 : 2'd2;
        group_bits_next  = enc_bits;
        group_count_next = n[1:0];
      end
    end else begin
      if (sext == SEXTET_BAD) begin
        bad_input_next = 1'b1;
      end
      if (n == 3'd4) begin
        produce          = 1'b1;
        job.bits         = dec_bits;
        job.last_idx     = 2'd2;
        group_bits_next  = 24'd0;
        group_count_next = 2'd0;
      end else begin
        produce          = last_in;
        group_bits_next  = dec_bits;
        group_count_next = n[1:0];
        case (n)
          3'd1: begin
            // lone final character: one zero byte, flagged
            job.bits       = 24'd0;
            job.last_idx   = 2'd0;
            if (last_in) begin
              bad_input_next = 1'b1;
            end
          end
          3'd2: begin
            job.bits     = {dec_bits[11:0], 12'd0};
            job.last_idx = 2'd0;
          end
          default: begin
            job.bits     = {dec_bits[17:0], 6'd0};
            job.last_idx = 2'd1;
          end
        endcase
      end
      job.error = bad_input_next;
    end
    if (last_in) begin
      group_bits_next  = 24'd0;
      group_count_next = 2'd0;
      bad_input_next   = 1'b0;
    end
  end

  assign job_valid = accept && produce;

  // Update mode and group state; a mode write drops any partial group
  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= MODE_ENCODE;
      group_bits  <= 24'd0;
      group_count <= 2'd0;
      bad_input   <= 1'b0;
    end else if (cfg_we) begin
      mode        <= cfg_wdata;
      group_bits  <= 24'd0;
      group_count <= 2'd0;
      bad_input   <= 1'b0;
    end else if (accept) begin
      group_bits  <= group_bits_next;
      group_count <= group_count_next;
      bad_input   <= bad_input_next;
    end
  end

endmodule

// ===== design/b64u_queue.sv =====
// Two-entry job queue between the front and back ends of the codec.
// Head slot feeds the back end; tail slot absorbs a stall. Depends on b64u_pkg.
module b64u_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push_valid,
  output logic             push_ready,
  input  b64u_pkg::job_t   push_job,
  output logic             pop_valid,
  input  logic             pop_ready,
  output b64u_pkg::job_t   pop_job
);
  import b64u_pkg::*;

  job_t head;
  job_t tail;
  logic head_valid;
  logic tail_valid;
  logic push;
  logic pop;

  assign push_ready = !tail_valid;
  assign push       = push_valid && push_ready;
  assign pop        = head_valid && pop_ready;
  assign pop_valid  = head_valid;
  assign pop_job    = head;

  // Track occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      head_valid <= 1'b0;
      tail_valid <= 1'b0;
    end else if (pop && push) begin
      head_valid <= 1'b1;
    end else if (pop) begin
      head_valid <= tail_valid;
      tail_valid <= 1'b0;
    end else if (push) begin
      if (head_valid) begin
        tail_valid <= 1'b1;
      end else begin
        head_valid <= 1'b1;
      end
    end
  end

  // Move payload: advance tail into head on pop, land new jobs in the free slot
  always_ff @(posedge clk) begin
    if (pop && push) begin
      head <= push_job;
    end else if (pop) begin
      head <= tail;
    end else if (push) begin
      if (head_valid) begin
        tail <= push_job;
      end else begin
        head <= push_job;
      end
    end
  end

endmodule

// ===== design/b64u_back.sv =====
// Back end of the base64url codec: expands each job into result transfers.
// Registered: one char or byte per cycle while out_ready is high. Depends on b64u_pkg.
module b64u_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             job_valid,
  output logic             job_ready,
  input  b64u_pkg::job_t   job,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [7:0]       data_out,
  output logic             last_out,
  output logic             error
);
  import b64u_pkg::*;

  logic [1:0] idx;
  logic       advance;
  logic       emit;
  logic       final_one;
  logic [5:0] sext;
  logic [7:0] byte_sel;
  logic [7:0] data_sel;

  assign advance   = !out_valid || out_ready;
  assign emit      = advance && job_valid;
  assign final_one = (idx == job.last_idx);
  assign job_ready = advance && final_one;

  // Select the sextet or byte at the current position of the group
  always_comb begin
    case (idx)
      2'd0:    sext = job.bits[23:18];
      2'd1:    sext = job.bits[17:12];
      2'd2:    sext = job.bits[11:6];
      default: sext = job.bits[5:0];
    endcase
    case (idx)
      2'd0:    byte_sel = job.bits[23:16];
      2'd1:    byte_sel = job.bits[15:8];
      default: byte_sel = job.bits[7:0];
    endcase
    data_sel = (job.mode == MODE_ENCODE) ? sextet_char(sext) : byte_sel;
  end

  // Step through the job's results
  always_ff @(posedge clk) begin
    if (rst) begin
      idx       <= 2'd0;
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
      idx       <= final_one ? 2'd0 : idx + 2'd1;
    end else if (advance) begin
      out_valid <= 1'b0;
    end
  end

  // Load the output register
  always_ff @(posedge clk) begin
    if (emit) begin
      data_out <= data_sel;
      last_out <= job.last && final_one;
      error    <= job.error;
    end
  end

endmodule

// ===== design/base64url_codec.sv =====
// Top level of the unpadded base64url encoder/decoder.
// Ties together b64u_front, b64u_queue and b64u_back. Depends on b64u_pkg.
//
// Streams unpadded base64url (A-Z a-z 0-9 - _). cfg_we writes the mode bit
// (0 encode, 1 decode) and drops any partial group; write it only while idle.
// The front end takes one input transfer per cycle whenever the two-entry job
// queue has room. The back end drives one result transfer per cycle from its
// output register while out_ready is high, which bounds the sustained rate when
// encoding, as each 3 bytes give 4 characters. Results of a group pass through
// the queue head slot and then the back end output register. The error
// output is sticky within a message and clears after the result marked last_out.
module base64url_codec (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic       cfg_wdata,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] data_in,
  input  logic       last_in,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] data_out,
  output logic       last_out,
  output logic       error
);
  import b64u_pkg::*;

  job_t front_job;
  job_t back_job;
  logic front_valid;
  logic front_ready;
  logic back_valid;
  logic back_ready;

  b64u_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .data_in   (data_in),
    .last_in   (last_in),
    .job_valid (front_valid),
    .job_ready (front_ready),
    .job       (front_job)
  );

  b64u_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (front_valid),
    .push_ready (front_ready),
    .push_job   (front_job),
    .pop_valid  (back_valid),
    .pop_ready  (back_ready),
    .pop_job    (back_job)
  );

  b64u_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (back_valid),
    .job_ready (back_ready),
    .job       (back_job),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .data_out  (data_out),
    .last_out  (last_out),
    .error     (error)
  );

endmodule
